// ----- rtl/sfr_pkg.sv -----
// Shared types and codes for the stuffed frame receiver.
package sfr_pkg;

  localparam int ByteW  = 8;
  localparam int PhaseW = 3;
  localparam int KindW  = 3;
  localparam int CfgIdxW = 2;

  // Receive phases.
  localparam logic [PhaseW-1:0] PH_IDLE = 3'd0;
  localparam logic [PhaseW-1:0] PH_CMD  = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEN  = 3'd2;
  localparam logic [PhaseW-1:0] PH_DATA = 3'd3;
  localparam logic [PhaseW-1:0] PH_CSUM = 3'd4;

  // Byte kinds reported with each item.
  localparam logic [KindW-1:0] KIND_START = 3'd0;
  localparam logic [KindW-1:0] KIND_CMD   = 3'd1;
  localparam logic [KindW-1:0] KIND_LEN   = 3'd2;
  localparam logic [KindW-1:0] KIND_DATA  = 3'd3;
  localparam logic [KindW-1:0] KIND_CSUM  = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_BYTE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_MASK = 2'd2;

  // Configuration reset values.
  localparam logic [ByteW-1:0] START_BYTE_RST  = 8'd126;
  localparam logic [ByteW-1:0] ESCAPE_BYTE_RST = 8'd125;
  localparam logic [ByteW-1:0] ESCAPE_MASK_RST = 8'd32;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  bytes_left;
    logic [ByteW-1:0]  running_sum;
    logic              escape_pending;
  } rx_state_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic [KindW-1:0] byte_kind;
    logic             frame_end;
    logic             frame_good;
  } rx_result_t;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] escape_byte;
    logic [ByteW-1:0] escape_mask;
  } rx_cfg_t;

endpackage

// ----- rtl/sfr_decode.sv -----
// Unescaping and frame phase decode for one received byte.
module sfr_decode (
  input  sfr_pkg::rx_state_t  state,
  input  sfr_pkg::rx_cfg_t    cfg,
  input  logic [7:0]          rx_byte,
  output sfr_pkg::rx_state_t  state_next,
  output logic                emit,
  output sfr_pkg::rx_result_t result
);
  import sfr_pkg::*;

  logic [ByteW-1:0] b;
  logic [ByteW-1:0] sum_add;
  logic [ByteW-1:0] left_dec;

  assign b        = state.escape_pending ? (rx_byte ^ cfg.escape_mask) : rx_byte;
  assign sum_add  = state.running_sum + b;
  assign left_dec = state.bytes_left - 8'd1;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    result.frame_byte = b;
    result.byte_kind  = KIND_START;
    result.frame_end  = 1'b0;
    result.frame_good = 1'b0;
    if (rx_byte == cfg.escape_byte) begin
      // An escape only arms the mask, even when one is already armed.
      state_next.escape_pending = 1'b1;
    end else begin
      state_next.escape_pending = 1'b0;
      case (state.phase)
        PH_CMD: begin
          state_next.running_sum = sum_add;
          state_next.phase       = PH_LEN;
          emit                   = 1'b1;
          result.byte_kind       = KIND_CMD;
        end
        PH_LEN: begin
          state_next.running_sum = sum_add;
          state_next.bytes_left  = b;
          state_next.phase       = PH_DATA;
          emit                   = 1'b1;
          result.byte_kind       = KIND_LEN;
        end
        PH_DATA: begin
          state_next.running_sum = sum_add;
          emit                   = 1'b1;
          result.byte_kind       = KIND_DATA;
          if (state.bytes_left == '0) begin
            // A zero length frame is aborted on this byte.
            state_next.phase = PH_IDLE;
            result.frame_end = 1'b1;
          end else begin
            state_next.bytes_left = left_dec;
            if (left_dec == '0) begin
              state_next.phase = PH_CSUM;
            end
          end
        end
        PH_CSUM: begin
          state_next.phase  = PH_IDLE;
          emit              = 1'b1;
          result.byte_kind  = KIND_CSUM;
          result.frame_end  = 1'b1;
          result.frame_good = (b == state.running_sum);
        end
        default: begin
          // Idle, and any unused phase code, hunts for the start byte.
          state_next.phase = PH_IDLE;
          if (b == cfg.start_byte) begin
            state_next.running_sum = b;
            state_next.phase       = PH_CMD;
            emit                   = 1'b1;
            result.byte_kind       = KIND_START;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/stuffed_frame_receiver.sv -----
// Top level of the byte-stuffed frame receiver with additive checksum.
//
// The receiver takes one raw line byte per item and returns each byte that
// belongs to a frame, unescaped, together with its kind (start, command,
// length, payload, checksum). An escape byte produces nothing and causes
// the next byte to be XORed with the escape mask. The checksum item carries
// frame_end with frame_good set when the 8-bit wrapping sum of start,
// command, length and payload bytes matches; a zero length frame ends on
// the following byte with frame_end set and frame_good clear. Throughput is
// one item per clock cycle while out_ready keeps the result register free:
// a received byte sits in an input register, then the decode logic updates
// the frame state and loads the result register, which drives the outputs,
// once that register can take its output.
// The input side keeps accepting while a finished result waits to be
// taken, as long as that result drains by the time the held byte needs the
// output register. Configuration registers take effect on the next byte
// decoded and should be written while no item is in flight.
module stuffed_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  // Configuration write port.
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Received byte channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic [2:0] byte_kind,
  output logic       frame_end,
  output logic       frame_good
);
  import sfr_pkg::*;

  rx_cfg_t          cfg;
  rx_state_t        state;
  rx_state_t        state_next;
  rx_result_t       dec_result;
  rx_result_t       result;
  logic             dec_emit;
  logic             in_full;
  logic [ByteW-1:0] in_byte;
  logic             advance;

  // The held byte is decoded when the result register can take its output.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte  <= START_BYTE_RST;
      cfg.escape_byte <= ESCAPE_BYTE_RST;
      cfg.escape_mask <= ESCAPE_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:  cfg.start_byte  <= cfg_data;
        CFG_ESCAPE_BYTE: cfg.escape_byte <= cfg_data;
        CFG_ESCAPE_MASK: cfg.escape_mask <= cfg_data;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  sfr_decode u_decode (
    .state      (state),
    .cfg        (cfg),
    .rx_byte    (in_byte),
    .state_next (state_next),
    .emit       (dec_emit),
    .result     (dec_result)
  );

  // Frame state moves once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PH_IDLE;
      state.bytes_left     <= '0;
      state.running_sum    <= '0;
      state.escape_pending <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && dec_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec_emit) begin
      result <= dec_result;
    end
  end

  assign frame_byte = result.frame_byte;
  assign byte_kind  = result.byte_kind;
  assign frame_end  = result.frame_end;
  assign frame_good = result.frame_good;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the byte-stuffed frame receiver.
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  localparam int DRAIN_CYCLES      = 8;
  localparam int STALL_LIMIT       = 2000;
  localparam int REPORT_LIMIT      = 10;
  localparam int RESULTS_PER_PHASE = 90;

  // Index 3 has no register behind it, so a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // How a directed row gets its expectation: from the line decoder below,
  // not at all (the byte is swallowed), or typed into the table.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_TYPED} row_how_t;

  typedef struct packed {
    logic [ByteW-1:0] raw;
    row_how_t         how;
    rx_result_t       want;
  } script_row_t;

  // Directed bytes under the reset settings: start 7E, escape 7D, mask 20.
  // The rows walk a clean frame with a matching checksum, a frame with a
  // wrong checksum, a zero length frame, an escape after an escape, an
  // escaped byte in idle that is not a start, a frame opened by an escaped
  // start and the escape value itself carried as data.
  localparam script_row_t SCRIPT [26] = '{
    '{8'h7D, ROW_NONE,    '0},
    '{8'h00, ROW_NONE,    '0},
    '{8'h7E, ROW_TYPED,   '{8'h7E, KIND_START, 1'b0, 1'b0}},
    '{8'h01, ROW_TYPED,   '{8'h01, KIND_CMD,   1'b0, 1'b0}},
    '{8'h02, ROW_TYPED,   '{8'h02, KIND_LEN,   1'b0, 1'b0}},
    '{8'h7D, ROW_NONE,    '0},
    '{8'h5E, ROW_PREDICT, '0},
    '{8'hFF, ROW_TYPED,   '{8'hFF, KIND_DATA,  1'b0, 1'b0}},
    '{8'hFE, ROW_TYPED,   '{8'hFE, KIND_CSUM,  1'b1, 1'b1}},
    '{8'h7E, ROW_TYPED,   '{8'h7E, KIND_START, 1'b0, 1'b0}},
    '{8'hFF, ROW_TYPED,   '{8'hFF, KIND_CMD,   1'b0, 1'b0}},
    '{8'h01, ROW_TYPED,   '{8'h01, KIND_LEN,   1'b0, 1'b0}},
    '{8'h00, ROW_TYPED,   '{8'h00, KIND_DATA,  1'b0, 1'b0}},
    '{8'h00, ROW_TYPED,   '{8'h00, KIND_CSUM,  1'b1, 1'b0}},
    '{8'h7E, ROW_TYPED,   '{8'h7E, KIND_START, 1'b0, 1'b0}},
    '{8'h80, ROW_TYPED,   '{8'h80, KIND_CMD,   1'b0, 1'b0}},
    '{8'h00, ROW_TYPED,   '{8'h00, KIND_LEN,   1'b0, 1'b0}},
    '{8'h55, ROW_TYPED,   '{8'h55, KIND_DATA,  1'b1, 1'b0}},
    '{8'h7D, ROW_NONE,    '0},
    '{8'h7D, ROW_NONE,    '0},
    '{8'h5E, ROW_PREDICT, '0},
    '{8'h7D, ROW_NONE,    '0},
    '{8'h5D, ROW_PREDICT, '0},
    '{8'h00, ROW_TYPED,   '{8'h00, KIND_LEN,   1'b0, 1'b0}},
    '{8'h7D, ROW_NONE,    '0},
    '{8'h20, ROW_PREDICT, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ByteW-1:0]   rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ByteW-1:0]   frame_byte;
  logic [KindW-1:0]   byte_kind;
  logic               frame_end;
  logic               frame_good;

  stuffed_frame_receiver uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .byte_kind  (byte_kind),
    .frame_end  (frame_end),
    .frame_good (frame_good)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The testbench's own copy of the settings and of the decoder state.
  logic [ByteW-1:0]  opener   = START_BYTE_RST;
  logic [ByteW-1:0]  esc_code = ESCAPE_BYTE_RST;
  logic [ByteW-1:0]  esc_xor  = ESCAPE_MASK_RST;
  logic [PhaseW-1:0] stage    = PH_IDLE;
  logic [ByteW-1:0]  payload_left = '0;
  logic [ByteW-1:0]  frame_sum = '0;
  logic              unmask_next = 1'b0;

  // Results that are not yet matched are held here, oldest first.
  rx_result_t decoded_q[$];

  // The sender tags each item with how its expectation is formed.
  row_how_t   row_how = ROW_PREDICT;
  rx_result_t row_want = '0;

  int send_pct = 0;
  int take_pct = 0;
  int send_calm = 0;
  int take_calm = 0;

  int mismatches = 0;
  int bytes_in = 0;
  int results_made = 0;
  int checked = 0;
  int frames_closed = 0;
  int frames_good = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  // Runs one received line byte through the deframing rules. The return
  // value tells whether the byte belongs to a frame; r then holds it.
  function automatic bit deframe_byte(input logic [ByteW-1:0] raw, output rx_result_t r);
    logic [ByteW-1:0] b;
    bit               made;
    b = raw;
    r = '0;
    made = 1'b1;
    if (raw == esc_code) begin
      // An escape, even right after another one, only arms the mask.
      unmask_next = 1'b1;
      made = 1'b0;
    end else begin
      if (unmask_next) begin
        b = raw ^ esc_xor;
        unmask_next = 1'b0;
      end
      r.frame_byte = b;
      case (stage)
        PH_CMD: begin
          frame_sum = frame_sum + b;
          stage = PH_LEN;
          r.byte_kind = KIND_CMD;
        end
        PH_LEN: begin
          frame_sum = frame_sum + b;
          payload_left = b;
          stage = PH_DATA;
          r.byte_kind = KIND_LEN;
        end
        PH_DATA: begin
          frame_sum = frame_sum + b;
          r.byte_kind = KIND_DATA;
          if (payload_left == '0) begin
            // A zero length frame is cut short on the byte after the length.
            stage = PH_IDLE;
            r.frame_end = 1'b1;
          end else begin
            payload_left = payload_left - 1'b1;
            if (payload_left == '0) stage = PH_CSUM;
          end
        end
        PH_CSUM: begin
          stage = PH_IDLE;
          r.byte_kind = KIND_CSUM;
          r.frame_end = 1'b1;
          r.frame_good = (b == frame_sum);
        end
        default: begin
          if (b == opener) begin
            frame_sum = b;
            stage = PH_CMD;
            r.byte_kind = KIND_START;
          end else begin
            stage = PH_IDLE;
            made = 1'b0;
          end
        end
      endcase
    end
    return made;
  endfunction

  // Accepted items on both channels are handled here at the rising edge.
  // An accepted input is decoded first, so its result is queued before any
  // output of the same edge is compared.
  always @(posedge clk) begin : scoreboard
    rx_result_t want;
    rx_result_t seen;
    bit         made;
    if (!rst) begin
      if (in_valid && in_ready) begin
        bytes_in++;
        made = deframe_byte(rx_byte, want);
        if (made) results_made++;
        case (row_how)
          ROW_PREDICT: if (made) decoded_q.push_back(want);
          ROW_TYPED:   decoded_q.push_back(row_want);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = {frame_byte, byte_kind, frame_end, frame_good};
        if (decoded_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result with none waiting: byte %h kind %0d end %b good %b",
                     $realtime, seen.frame_byte, seen.byte_kind, seen.frame_end,
                     seen.frame_good);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          checked++;
          if (want.frame_end) frames_closed++;
          if (want.frame_good) frames_good++;
          if (seen.frame_byte !== want.frame_byte || seen.byte_kind !== want.byte_kind ||
              seen.frame_end !== want.frame_end || seen.frame_good !== want.frame_good) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: expected byte %h kind %0d end %b good %b, got %h %0d %b %b",
                       $realtime, want.frame_byte, want.byte_kind, want.frame_end,
                       want.frame_good, seen.frame_byte, seen.byte_kind, seen.frame_end,
                       seen.frame_good);
            mismatches++;
          end
        end
      end
    end
  end

  // The run is abandoned when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no item accepted for %0d cycles.", STALL_LIMIT);
      $display("stuffed_frame_receiver verification failed");
      $finish;
    end
  end

  // The receiver stalls at the current rate, with an occasional calm stretch
  // in which it takes every result.
  always @(negedge clk) begin
    if (take_calm > 0) begin
      take_calm--;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < take_pct) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) take_calm = $urandom_range(10, 40);
    end
  end

  function automatic bit sender_waits();
    bit w;
    w = 1'b0;
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 99) < send_pct) begin
      w = 1'b1;
    end else if ($urandom_range(0, 63) == 0) begin
      send_calm = $urandom_range(10, 40);
    end
    return w;
  endfunction

  // Offers one byte, starting and ending at a falling edge. Valid is raised
  // without looking at ready and held until the byte is taken.
  task automatic send_item(input logic [ByteW-1:0] b);
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
  endtask

  // The escape value can only be carried as data when masking moves it off
  // the escape value; otherwise the generator picks the next value.
  function automatic logic [ByteW-1:0] sendable(input logic [ByteW-1:0] b);
    return (b == esc_code && (b ^ esc_xor) == esc_code) ? b + 8'd1 : b;
  endfunction

  // Sends one frame byte on the line, escaped when it has to be and now
  // and then when it does not.
  task automatic send_logical(input logic [ByteW-1:0] b);
    if ((b == esc_code || $urandom_range(0, 9) == 0) && (b ^ esc_xor) != esc_code) begin
      send_item(esc_code);
      send_item(b ^ esc_xor);
    end else begin
      send_item(b);
    end
  endtask

  // Builds a frame with random content under the current settings. Most
  // lengths are short, a few reach far up the range; most checksums are
  // right, and about one frame in ten is cut off early.
  task automatic send_frame();
    logic [ByteW-1:0] frame_q[$];
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] sum;
    int               pick;
    int               n;
    frame_q = {};
    frame_q.push_back(sendable(opener));
    frame_q.push_back(sendable(8'($urandom)));
    pick = $urandom_range(0, 99);
    if (pick < 70) len = 8'($urandom_range(0, 6));
    else if (pick < 97) len = 8'($urandom_range(7, 24));
    else len = 8'($urandom_range(25, 255));
    len = sendable(len);
    frame_q.push_back(len);
    if (len == '0) begin
      frame_q.push_back(sendable(8'($urandom)));
    end else begin
      repeat (len) frame_q.push_back(sendable(8'($urandom)));
      sum = '0;
      foreach (frame_q[i]) sum = sum + frame_q[i];
      if ($urandom_range(0, 99) < 85) frame_q.push_back(sendable(sum));
      else frame_q.push_back(sendable(8'($urandom)));
    end
    n = frame_q.size();
    if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n - 1);
    for (int k = 0; k < n; k++) send_logical(frame_q[k]);
  endtask

  // Writes all three registers, optionally followed by a write to the
  // unused index, and keeps the testbench copy in step.
  task automatic load_settings(input logic [ByteW-1:0] s, input logic [ByteW-1:0] e,
                               input logic [ByteW-1:0] m, input bit stray);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data <= s;
    @(negedge clk);
    cfg_index <= CFG_ESCAPE_BYTE;
    cfg_data <= e;
    @(negedge clk);
    cfg_index <= CFG_ESCAPE_MASK;
    cfg_data <= m;
    @(negedge clk);
    if (stray) begin
      cfg_index <= CFG_UNUSED;
      cfg_data <= 8'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    opener = s;
    esc_code = e;
    esc_xor = m;
    settings_used++;
  endtask

  initial begin
    int goal;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, run back to back under the reset settings.
    foreach (SCRIPT[i]) begin
      row_how = SCRIPT[i].how;
      row_want = SCRIPT[i].want;
      send_item(SCRIPT[i].raw);
    end
    row_how = ROW_PREDICT;

    // Random phases. Each one starts from a quiet block, may load new
    // settings, and picks a pattern of idling on the two channels.
    for (int p = 0; p < 6; p++) begin
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clk);
      case (p)
        1: load_settings(8'h00, 8'hFF, 8'hFF, 1'b1);
        2: load_settings(8'hFF, 8'h00, 8'h00, 1'b0);
        3: load_settings(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)), 1'b0);
        4: load_settings(8'h7E, 8'h7E, 8'h01, 1'b0);
        5: load_settings(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)), 1'b1);
        default: ;
      endcase
      case (p % 4)
        0: begin send_pct = 0;  take_pct = 0;  end
        1: begin send_pct = 74; take_pct = 0;  end
        2: begin send_pct = 0;  take_pct = 74; end
        default: begin send_pct = 35; take_pct = 35; end
      endcase
      goal = results_made + RESULTS_PER_PHASE;
      while (results_made < goal) begin
        // Now and then the line goes silent until every result is out.
        if ($urandom_range(0, 29) == 0) hold_until_drained();
        // Line noise between frames: any value, escapes included.
        if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 4)) send_item(8'($urandom));
        send_frame();
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (decoded_q.size() != 0) begin
      $display("%0d results never arrived.", decoded_q.size());
      mismatches++;
    end

    $display("Sent %0d line bytes under %0d register settings and four idling patterns.",
             bytes_in, settings_used);
    $display("Checked %0d frame bytes; %0d frames closed, %0d with a matching checksum.",
             checked, frames_closed, frames_good);
    if (mismatches == 0) begin
      $display("stuffed_frame_receiver verification clean");
    end else begin
      $display("stuffed_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
